// ----- src/urey_bradley_bond_force_macros.svh -----
// Assertion macros used by the checker of the bond-force block.
`ifndef UREY_BRADLEY_BOND_FORCE_MACROS_SVH
`define UREY_BRADLEY_BOND_FORCE_MACROS_SVH

// A condition that must never hold while out of reset.
`define UBBF_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("ubbf: forbidden condition seen");

// A condition in one cycle that forces another in the next cycle.
`define UBBF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ubbf: next-cycle rule broken");

`endif

// ----- src/ubbf_pkg.sv -----
// Shared constants, types and the micro-program of the bond-force block.
package ubbf_pkg;

    localparam int INDEX_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int COEF_FRAC      = 24;
    localparam int CFG_W          = 32;
    localparam int CFG_ADDR_W     = 1;
    localparam int ACC_W          = 48;

    localparam logic [CFG_ADDR_W-1:0] CFG_CUBIC   = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_QUARTIC = 1'd1;

    // Largest magnitude of an intermediate value.
    localparam logic [63:0] VAL_LIM = 64'h3FFF_FFFF_FFFF_FFFF;

    // Operand and destination codes of the micro-program.
    typedef logic [4:0] t_opd;
    localparam t_opd OPD_X    = 5'd0;
    localparam t_opd OPD_X2   = 5'd1;
    localparam t_opd OPD_C    = 5'd2;
    localparam t_opd OPD_C3   = 5'd3;
    localparam t_opd OPD_Q    = 5'd4;
    localparam t_opd OPD_K    = 5'd5;
    localparam t_opd OPD_KX   = 5'd6;
    localparam t_opd OPD_KX2  = 5'd7;
    localparam t_opd OPD_PF   = 5'd8;
    localparam t_opd OPD_PE   = 5'd9;
    localparam t_opd OPD_ONE  = 5'd10;
    localparam t_opd OPD_CX   = 5'd11;
    localparam t_opd OPD_C15X = 5'd12;
    localparam t_opd OPD_QX2  = 5'd13;
    localparam t_opd OPD_Q2X2 = 5'd14;
    localparam t_opd OPD_G    = 5'd15;
    localparam t_opd OPD_D0   = 5'd16;
    localparam t_opd OPD_D1   = 5'd17;
    localparam t_opd OPD_D2   = 5'd18;
    localparam t_opd OPD_E    = 5'd19;
    localparam t_opd OPD_FX   = 5'd20;
    localparam t_opd OPD_FY   = 5'd21;
    localparam t_opd OPD_FZ   = 5'd22;

    // Operation kinds.
    typedef logic [1:0] t_op;
    localparam t_op OP_MUL = 2'd0;
    localparam t_op OP_ADD = 2'd1;
    localparam t_op OP_DIV = 2'd2;

    // Rounding shift codes of a scaled product.
    typedef logic [2:0] t_shc;
    localparam t_shc SH_F   = 3'd0;
    localparam t_shc SH_FM1 = 3'd1;
    localparam t_shc SH_C   = 3'd2;
    localparam t_shc SH_CP1 = 3'd3;
    localparam t_shc SH_CM1 = 3'd4;

    typedef struct packed {
        t_op  op;
        t_opd dst;
        t_opd src_a;
        t_opd src_b;
        t_shc sh;
    } t_uop;

    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] LAST_PC = 4'd15;

    // Micro-program: polynomial terms, force factor and energy, then one force axis per step.
    function automatic t_uop prog_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        u = '{OP_ADD, OPD_PF, OPD_PF, OPD_ONE, SH_F};
        unique case (pc)
            4'd0:    u = '{OP_MUL, OPD_X2,   OPD_X,   OPD_X,    SH_F};
            4'd1:    u = '{OP_MUL, OPD_CX,   OPD_C,   OPD_X,    SH_C};
            4'd2:    u = '{OP_MUL, OPD_C15X, OPD_C3,  OPD_X,    SH_CP1};
            4'd3:    u = '{OP_MUL, OPD_QX2,  OPD_Q,   OPD_X2,   SH_C};
            4'd4:    u = '{OP_MUL, OPD_Q2X2, OPD_Q,   OPD_X2,   SH_CM1};
            4'd5:    u = '{OP_MUL, OPD_KX,   OPD_K,   OPD_X,    SH_F};
            4'd6:    u = '{OP_MUL, OPD_KX2,  OPD_K,   OPD_X2,   SH_F};
            4'd7:    u = '{OP_ADD, OPD_PF,   OPD_ONE, OPD_C15X, SH_F};
            4'd8:    u = '{OP_ADD, OPD_PF,   OPD_PF,  OPD_Q2X2, SH_F};
            4'd9:    u = '{OP_ADD, OPD_PE,   OPD_ONE, OPD_CX,   SH_F};
            4'd10:   u = '{OP_ADD, OPD_PE,   OPD_PE,  OPD_QX2,  SH_F};
            4'd11:   u = '{OP_MUL, OPD_G,    OPD_KX,  OPD_PF,   SH_FM1};
            4'd12:   u = '{OP_MUL, OPD_E,    OPD_KX2, OPD_PE,   SH_F};
            4'd13:   u = '{OP_DIV, OPD_FX,   OPD_G,   OPD_D0,   SH_F};
            4'd14:   u = '{OP_DIV, OPD_FY,   OPD_G,   OPD_D1,   SH_F};
            4'd15:   u = '{OP_DIV, OPD_FZ,   OPD_G,   OPD_D2,   SH_F};
            default: u = '{OP_ADD, OPD_PF,   OPD_PF,  OPD_ONE,  SH_F};
        endcase
        return u;
    endfunction

endpackage

// ----- src/urey_bradley_bond_force.sv -----
// Quartic bond-stretch force and energy unit with a shared multiplier and divider.
//
// Usage:
// - One pair enters on the s_axis channel; the result leaves on m_axis.
//   s_axis_tlast marks the last pair of a batch and comes back on m_axis_tlast.
// - Coefficients are written through i_cfg_we/i_cfg_addr/i_cfg_wdata while idle.
// - One item runs in order: squares of the three distance components, a square
//   root, the stretch, 9 scaled products, 4 saturating adds, three forces from
//   the bit-serial divider and a final step that closes the energy sum. With zero
//   distance each force step skips the divider and writes a zero force.
// - A new pair is taken only after the result's transfer on m_axis and a return to idle.
// - s_axis_tready is high only while the block is idle; one item is in
//   flight at a time.
// - When the receiver stalls, the result holds on m_axis until its transfer.
// - Reset clears the sequencer, both coefficients and the energy sum.
// - The energy sum is cleared after the result of the last pair.
module urey_bradley_bond_force
    import ubbf_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int IN_BITS   = 255 + 2 * INDEX_BITS,
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS  = 176 + 2 * INDEX_BITS,
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, ideal_length, force_constant,
    // atom_a_index, atom_b_index
    input  logic [IN_W-1:0]       s_axis_tdata,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // atom_a_out, atom_b_out, force_x, force_y, force_z, pair_energy, energy_total
    output logic [OUT_W-1:0]      m_axis_tdata,
    output logic                  m_axis_tlast,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQ   = 4'd1;
    localparam logic [3:0] S_SQRT = 4'd2;
    localparam logic [3:0] S_X    = 4'd3;
    localparam logic [3:0] S_EXEC = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_MFIN = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_DRND = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    localparam int IA_LO = 255;
    localparam int IB_LO = 255 + INDEX_BITS;

    logic [3:0]            r_state, n_state;
    logic [6:0]            r_cnt, n_cnt;
    logic [PC_W-1:0]       r_pc, n_pc;
    logic signed [32:0]    r_d0, n_d0, r_d1, n_d1, r_d2, n_d2;
    logic [30:0]           r_r0, n_r0;
    logic signed [31:0]    r_k, n_k;
    logic [INDEX_BITS-1:0] r_ia, n_ia, r_ib, n_ib;
    logic                  r_last, n_last;
    logic [127:0]          r_acc, n_acc;
    logic [34:0]           r_rem, n_rem;
    logic [33:0]           r_root, n_root;
    logic [32:0]           r_q, n_q;
    logic                  r_ovf, n_ovf;
    logic [63:0]           r_ma, n_ma, r_mb, n_mb;
    logic                  r_neg, n_neg;
    logic signed [63:0]    r_x, n_x, r_x2, n_x2, r_cx, n_cx, r_c15x, n_c15x;
    logic signed [63:0]    r_qx2, n_qx2, r_q2x2, n_q2x2, r_kx, n_kx, r_kx2, n_kx2;
    logic signed [63:0]    r_pf, n_pf, r_pe, n_pe, r_g, n_g, r_e, n_e;
    logic signed [31:0]    r_fx, n_fx, r_fy, n_fy, r_fz, n_fz;
    logic signed [31:0]    r_cubic, n_cubic, r_quartic, n_quartic;
    logic signed [47:0]    r_eacc, n_eacc, r_tot, n_tot;
    logic signed [31:0]    r_pe_out, n_pe_out;

    t_uop               uop;
    logic signed [63:0] val_a, val_b;
    logic [63:0]        mul_a, mul_b, sq_mag;
    logic [31:0]        limb_a, limb_b;
    logic [63:0]        pp;
    logic [127:0]       pp_sh;
    logic [1:0]         limb_pos;
    logic [6:0]         mf_sh;
    logic [127:0]       mf_rnd, mf_shd;
    logic [63:0]        mf_mag;
    logic signed [63:0] mf_val;
    logic [36:0]        sq_trem, sq_trial;
    logic               sq_ge;
    logic [34:0]        dv_sh;
    logic               dv_ge, dv_inc, dv_big;
    logic [33:0]        dv_qq;
    logic [31:0]        dv_mq, dv_res;
    logic signed [31:0] e32;
    logic signed [48:0] tot_sum;
    logic               wr_en;
    t_opd               wr_dst;
    logic signed [63:0] wr_val;
    logic               advance;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (s > $signed(VAL_LIM)) begin
            s = $signed(VAL_LIM);
        end else if (s < -$signed(VAL_LIM)) begin
            s = -$signed(VAL_LIM);
        end
        return s;
    endfunction

    function automatic logic [6:0] sh_amt(input t_shc c);
        logic [6:0] a;
        unique case (c)
            SH_F:    a = 7'(FRAC_BITS);
            SH_FM1:  a = 7'(FRAC_BITS - 1);
            SH_C:    a = 7'(COEF_FRAC);
            SH_CP1:  a = 7'(COEF_FRAC + 1);
            SH_CM1:  a = 7'(COEF_FRAC - 1);
            default: a = 7'(FRAC_BITS);
        endcase
        return a;
    endfunction

    // Operand read from the value registers by code.
    function automatic logic signed [63:0] opd_val(input t_opd s);
        logic signed [63:0] v;
        unique case (s)
            OPD_X:    v = r_x;
            OPD_X2:   v = r_x2;
            OPD_C:    v = 64'(r_cubic);
            OPD_C3:   v = (64'(r_cubic) <<< 1) + 64'(r_cubic);
            OPD_Q:    v = 64'(r_quartic);
            OPD_K:    v = 64'(r_k);
            OPD_KX:   v = r_kx;
            OPD_KX2:  v = r_kx2;
            OPD_PF:   v = r_pf;
            OPD_PE:   v = r_pe;
            OPD_ONE:  v = 64'sd1 <<< FRAC_BITS;
            OPD_CX:   v = r_cx;
            OPD_C15X: v = r_c15x;
            OPD_QX2:  v = r_qx2;
            OPD_Q2X2: v = r_q2x2;
            OPD_G:    v = r_g;
            OPD_D0:   v = 64'(r_d0);
            OPD_D1:   v = 64'(r_d1);
            OPD_D2:   v = 64'(r_d2);
            default:  v = '0;
        endcase
        return v;
    endfunction

    assign uop = prog_rom(r_pc);

    // Operand fetch for the current micro-op.
    always_comb begin
        val_a = opd_val(uop.src_a);
        val_b = opd_val(uop.src_b);
    end

    // Shared 32x32 limb multiplier; squares pick the axis from the counter.
    always_comb begin
        unique case (r_cnt[3:2])
            2'd0:    sq_mag = mag64(64'(r_d0));
            2'd1:    sq_mag = mag64(64'(r_d1));
            default: sq_mag = mag64(64'(r_d2));
        endcase
    end
    assign mul_a    = (r_state == S_SQ) ? sq_mag : r_ma;
    assign mul_b    = (r_state == S_SQ) ? sq_mag : r_mb;
    assign limb_a   = r_cnt[1] ? mul_a[63:32] : mul_a[31:0];
    assign limb_b   = r_cnt[0] ? mul_b[63:32] : mul_b[31:0];
    assign pp       = 64'(limb_a) * 64'(limb_b);
    assign limb_pos = {1'b0, r_cnt[1]} + {1'b0, r_cnt[0]};
    always_comb begin
        case (limb_pos)
            2'd0:    pp_sh = {64'd0, pp};
            2'd1:    pp_sh = {32'd0, pp, 32'd0};
            default: pp_sh = {pp, 64'd0};
        endcase
    end

    // Round to nearest, ties away from zero, then saturate the magnitude.
    assign mf_sh  = sh_amt(uop.sh);
    assign mf_rnd = r_acc + (128'd1 << (mf_sh - 7'd1));
    assign mf_shd = mf_rnd >> mf_sh;
    assign mf_mag = (|mf_shd[127:62]) ? VAL_LIM : mf_shd[63:0];
    assign mf_val = r_neg ? -$signed(mf_mag) : $signed(mf_mag);

    // One root bit per cycle from the top pair of the accumulator.
    assign sq_trem  = {r_rem, r_acc[67:66]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign sq_ge    = sq_trem >= sq_trial;

    // One quotient bit per cycle; quotient bits above 32 only set a flag.
    assign dv_sh  = {r_rem[33:0], r_acc[95]};
    assign dv_ge  = dv_sh >= {1'b0, r_root};
    assign dv_inc = {r_rem[33:0], 1'b0} >= {1'b0, r_root};
    assign dv_qq  = {1'b0, r_q} + 34'(dv_inc);
    assign dv_big = r_ovf || (dv_qq > 34'h0_8000_0000);
    assign dv_mq  = dv_big ? 32'h8000_0000 : dv_qq[31:0];
    assign dv_res = r_neg ? (32'd0 - dv_mq)
                          : ((dv_mq == 32'h8000_0000) ? 32'h7FFF_FFFF : dv_mq);

    // Pair energy clamped to 32 bits and the running sum clamped to 48 bits.
    always_comb begin
        if (r_e > 64'sh7FFF_FFFF) begin
            e32 = 32'sh7FFF_FFFF;
        end else if (r_e < -64'sh8000_0000) begin
            e32 = 32'sh8000_0000;
        end else begin
            e32 = r_e[31:0];
        end
    end
    assign tot_sum = 49'(r_eacc) + 49'(e32);

    // Sequencer and register updates.
    always_comb begin
        n_state = r_state;  n_cnt = r_cnt;  n_pc = r_pc;
        n_d0 = r_d0;  n_d1 = r_d1;  n_d2 = r_d2;  n_r0 = r_r0;  n_k = r_k;
        n_ia = r_ia;  n_ib = r_ib;  n_last = r_last;
        n_acc = r_acc;  n_rem = r_rem;  n_root = r_root;  n_q = r_q;  n_ovf = r_ovf;
        n_ma = r_ma;  n_mb = r_mb;  n_neg = r_neg;
        n_x = r_x;  n_x2 = r_x2;  n_cx = r_cx;  n_c15x = r_c15x;
        n_qx2 = r_qx2;  n_q2x2 = r_q2x2;  n_kx = r_kx;  n_kx2 = r_kx2;
        n_pf = r_pf;  n_pe = r_pe;  n_g = r_g;  n_e = r_e;
        n_fx = r_fx;  n_fy = r_fy;  n_fz = r_fz;
        n_cubic = r_cubic;  n_quartic = r_quartic;
        n_eacc = r_eacc;  n_tot = r_tot;  n_pe_out = r_pe_out;
        wr_en = 1'b0;  wr_dst = uop.dst;  wr_val = '0;  advance = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_d0 = $signed({s_axis_tdata[127], s_axis_tdata[127:96]})
                         - $signed({s_axis_tdata[31], s_axis_tdata[31:0]});
                    n_d1 = $signed({s_axis_tdata[159], s_axis_tdata[159:128]})
                         - $signed({s_axis_tdata[63], s_axis_tdata[63:32]});
                    n_d2 = $signed({s_axis_tdata[191], s_axis_tdata[191:160]})
                         - $signed({s_axis_tdata[95], s_axis_tdata[95:64]});
                    n_r0    = s_axis_tdata[222:192];
                    n_k     = s_axis_tdata[254:223];
                    n_ia    = s_axis_tdata[IA_LO +: INDEX_BITS];
                    n_ib    = s_axis_tdata[IB_LO +: INDEX_BITS];
                    n_last  = s_axis_tlast;
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                n_acc = r_acc + pp_sh;
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd11) begin
                    n_cnt   = '0;
                    n_rem   = '0;
                    n_root  = '0;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                n_acc  = r_acc << 2;
                n_rem  = sq_ge ? 35'(sq_trem - sq_trial) : sq_trem[34:0];
                n_root = {r_root[32:0], sq_ge};
                n_cnt  = r_cnt + 7'd1;
                if (r_cnt == 7'd33) begin
                    n_state = S_X;
                end
            end
            S_X: begin
                n_x     = $signed({30'd0, r_root}) - $signed({33'd0, r_r0});
                n_pc    = '0;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                case (uop.op)
                    OP_ADD: begin
                        wr_en   = 1'b1;
                        wr_val  = sat_add(val_a, val_b);
                        advance = 1'b1;
                    end
                    default: begin
                        if (uop.op == OP_DIV && r_root == '0) begin
                            wr_en   = 1'b1;
                            advance = 1'b1;
                        end else begin
                            n_ma    = mag64(val_a);
                            n_mb    = mag64(val_b);
                            n_neg   = val_a[63] ^ val_b[63];
                            n_acc   = '0;
                            n_cnt   = '0;
                            n_state = S_MUL;
                        end
                    end
                endcase
            end
            S_MUL: begin
                n_acc = r_acc + pp_sh;
                n_cnt = r_cnt + 7'd1;
                if (r_cnt[1:0] == 2'd3) begin
                    n_cnt   = '0;
                    n_rem   = '0;
                    n_q     = '0;
                    n_ovf   = 1'b0;
                    n_state = (uop.op == OP_DIV) ? S_DIV : S_MFIN;
                end
            end
            S_MFIN: begin
                wr_en   = 1'b1;
                wr_val  = mf_val;
                advance = 1'b1;
            end
            S_DIV: begin
                n_acc = r_acc << 1;
                n_rem = dv_ge ? 35'(dv_sh - {1'b0, r_root}) : dv_sh;
                n_q   = {r_q[31:0], dv_ge};
                n_ovf = r_ovf | r_q[32];
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd95) begin
                    n_state = S_DRND;
                end
            end
            S_DRND: begin
                wr_en   = 1'b1;
                wr_val  = 64'($signed(dv_res));
                advance = 1'b1;
            end
            S_DONE: begin
                if (tot_sum > 49'sh7FFF_FFFF_FFFF) begin
                    n_tot = 48'sh7FFF_FFFF_FFFF;
                end else if (tot_sum < -49'sh8000_0000_0000) begin
                    n_tot = 48'sh8000_0000_0000;
                end else begin
                    n_tot = tot_sum[47:0];
                end
                n_pe_out = e32;
                n_eacc   = r_last ? '0 : n_tot;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Step to the next micro-op or finish the item.
        if (advance) begin
            if (r_pc == LAST_PC) begin
                n_state = S_DONE;
            end else begin
                n_pc    = r_pc + 4'd1;
                n_state = S_EXEC;
            end
        end

        // Result write into the value registers.
        if (wr_en) begin
            unique case (wr_dst)
                OPD_X2:   n_x2   = wr_val;
                OPD_CX:   n_cx   = wr_val;
                OPD_C15X: n_c15x = wr_val;
                OPD_QX2:  n_qx2  = wr_val;
                OPD_Q2X2: n_q2x2 = wr_val;
                OPD_KX:   n_kx   = wr_val;
                OPD_KX2:  n_kx2  = wr_val;
                OPD_PF:   n_pf   = wr_val;
                OPD_PE:   n_pe   = wr_val;
                OPD_G:    n_g    = wr_val;
                OPD_E:    n_e    = wr_val;
                OPD_FX:   n_fx   = wr_val[31:0];
                OPD_FY:   n_fy   = wr_val[31:0];
                OPD_FZ:   n_fz   = wr_val[31:0];
                default:  n_x    = r_x;
            endcase
        end

        // Coefficient writes.
        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_CUBIC:   n_cubic   = i_cfg_wdata;
                CFG_QUARTIC: n_quartic = i_cfg_wdata;
                default:     n_cubic   = r_cubic;
            endcase
        end
    end

    // Control state, coefficients and the energy sum with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_pc      <= '0;
            r_cubic   <= '0;
            r_quartic <= '0;
            r_eacc    <= '0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_pc      <= n_pc;
            r_cubic   <= n_cubic;
            r_quartic <= n_quartic;
            r_eacc    <= n_eacc;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_d0 <= n_d0;  r_d1 <= n_d1;  r_d2 <= n_d2;  r_r0 <= n_r0;  r_k <= n_k;
        r_ia <= n_ia;  r_ib <= n_ib;  r_last <= n_last;
        r_acc <= n_acc;  r_rem <= n_rem;  r_root <= n_root;  r_q <= n_q;  r_ovf <= n_ovf;
        r_ma <= n_ma;  r_mb <= n_mb;  r_neg <= n_neg;
        r_x <= n_x;  r_x2 <= n_x2;  r_cx <= n_cx;  r_c15x <= n_c15x;
        r_qx2 <= n_qx2;  r_q2x2 <= n_q2x2;  r_kx <= n_kx;  r_kx2 <= n_kx2;
        r_pf <= n_pf;  r_pe <= n_pe;  r_g <= n_g;  r_e <= n_e;
        r_fx <= n_fx;  r_fy <= n_fy;  r_fz <= n_fz;
        r_tot <= n_tot;  r_pe_out <= n_pe_out;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tlast  = r_last;
    assign m_axis_tdata  = OUT_W'({r_tot, r_pe_out, r_fz, r_fy, r_fx, r_ib, r_ia});

endmodule

// ----- src/ubbf_checker.sv -----
// Port-level checker of the bond-force block and its bind.
`include "urey_bradley_bond_force_macros.svh"

module ubbf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready
);

    // One item at a time: no intake while a result is offered.
    `UBBF_ASSERT_NEVER(a_no_overlap, i_clk, i_rst_n, s_axis_tready && m_axis_tvalid)

    // An input transfer starts work, so intake closes next cycle.
    `UBBF_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // An output transfer is never followed at once by another result.
    `UBBF_ASSERT_NEXT(a_single_out, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready, !m_axis_tvalid)

    // A stalled result stays offered.
    `UBBF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

endmodule

bind urey_bradley_bond_force ubbf_checker u_ubbf_checker (.*);
